// ===== design/fdt_pkg.sv =====
package fdt_pkg;

	// table size and counter width
	localparam int FAULT_COUNT = 32;
	localparam int COUNT_BITS  = 8;
	localparam int LIMIT_BITS  = 8;
	localparam int ADDR_BITS   = (FAULT_COUNT > 1) ? $clog2(FAULT_COUNT) : 1;
	localparam int CMP_BITS    = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
	localparam int MASK_BITS   = 32;
	localparam int MASK_SPAN   = (FAULT_COUNT > MASK_BITS) ? FAULT_COUNT : MASK_BITS;
	localparam int TOTAL_BITS  = 7;
	localparam int ACT_BITS    = 6;

	// largest value a count register holds
	localparam logic [CMP_BITS-1:0] CNT_MAX = {CMP_BITS{1'b1}} >> (CMP_BITS - COUNT_BITS);
	localparam logic [TOTAL_BITS-1:0] TOTAL_CAP = TOTAL_BITS'(63);

	// request kinds
	localparam logic [1:0] KIND_REPORT    = 2'd0;
	localparam logic [1:0] KIND_CLEAR_ONE = 2'd1;
	localparam logic [1:0] KIND_CLEAR_ALL = 2'd2;
	localparam logic [1:0] KIND_LOAD      = 2'd3;

	// diagnostic results
	localparam logic [1:0] DIAG_PASS = 2'd0;
	localparam logic [1:0] DIAG_FAIL = 2'd1;

	typedef enum logic [1:0] {
		STAT_NONE     = 2'd0,
		STAT_PENDING  = 2'd1,
		STAT_DETECTED = 2'd2,
		STAT_HEALING  = 2'd3
	} fstat_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EVAL = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] fault_id;
		logic [1:0] diag_result;
		logic [7:0] confirm_limit;
		logic [7:0] heal_limit;
		logic [2:0] action_bits;
	} req_t;

	typedef struct packed {
		logic        error_flag;
		logic [1:0]  fault_state;
		logic        confirmed_now;
		logic [2:0]  fired_actions;
		logic [31:0] active_mask;
		logic [5:0]  active_count;
	} rsp_t;

	// per-fault debounce counters and status
	typedef struct packed {
		logic [COUNT_BITS-1:0] fail_count;
		logic [COUNT_BITS-1:0] pass_count;
		fstat_t                status;
	} cnt_rec_t;

	// per-fault definition
	typedef struct packed {
		logic [LIMIT_BITS-1:0] confirm_limit;
		logic [LIMIT_BITS-1:0] heal_limit;
		logic [2:0]            actions;
	} lim_rec_t;

	// evaluation result handed back to the control
	typedef struct packed {
		logic       cnt_we;
		cnt_rec_t   cnt_wdata;
		logic       lim_we;
		lim_rec_t   lim_wdata;
		logic       det_next;
		logic       clear_all;
		logic       error_flag;
		logic [1:0] fault_state;
		logic       confirmed_now;
		logic [2:0] fired_actions;
	} upd_t;

endpackage

// ===== design/fdt_ram.sv =====
module fdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/fdt_eval.sv =====
module fdt_eval (
	input  fdt_pkg::req_t     item,
	input  fdt_pkg::cnt_rec_t cnt,
	input  fdt_pkg::lim_rec_t lim,
	output fdt_pkg::upd_t     upd
);

	// saturating increment, capped at the limit and at the counter range
	function automatic logic [fdt_pkg::CMP_BITS-1:0] sat_inc(
		input logic [fdt_pkg::CMP_BITS-1:0] v,
		input logic [fdt_pkg::CMP_BITS-1:0] limit
	);
		logic [fdt_pkg::CMP_BITS-1:0] cap;
		cap = (limit < fdt_pkg::CNT_MAX) ? limit : fdt_pkg::CNT_MAX;
		return (v >= cap) ? cap : v + fdt_pkg::CMP_BITS'(1);
	endfunction

	logic                          id_ok;
	logic [fdt_pkg::CMP_BITS-1:0]  conf_lim;
	logic [fdt_pkg::CMP_BITS-1:0]  heal_lim;
	logic [fdt_pkg::CMP_BITS-1:0]  fail_new;
	logic [fdt_pkg::CMP_BITS-1:0]  pass_new;

	assign id_ok    = 32'(item.fault_id) < fdt_pkg::FAULT_COUNT;
	assign conf_lim = fdt_pkg::CMP_BITS'(lim.confirm_limit);
	assign heal_lim = fdt_pkg::CMP_BITS'(lim.heal_limit);
	assign fail_new = sat_inc(fdt_pkg::CMP_BITS'(cnt.fail_count), conf_lim);
	assign pass_new = sat_inc(fdt_pkg::CMP_BITS'(cnt.pass_count), heal_lim);

	always_comb begin
		upd                         = '0;
		upd.cnt_wdata               = cnt;
		upd.lim_wdata.confirm_limit = item.confirm_limit;
		upd.lim_wdata.heal_limit    = item.heal_limit;
		upd.lim_wdata.actions       = item.action_bits;
		upd.fault_state             = fdt_pkg::STAT_NONE;

		priority if (item.kind == fdt_pkg::KIND_CLEAR_ALL) begin
			upd.clear_all = 1'b1;
		end else if (!id_ok) begin
			upd.error_flag = 1'b1;
		end else if (item.kind == fdt_pkg::KIND_CLEAR_ONE) begin
			upd.cnt_we    = 1'b1;
			upd.cnt_wdata = '0;
		end else if (item.kind == fdt_pkg::KIND_LOAD) begin
			upd.lim_we      = 1'b1;
			upd.fault_state = cnt.status;
		end else if (item.diag_result == fdt_pkg::DIAG_FAIL) begin
			upd.cnt_we               = 1'b1;
			upd.cnt_wdata.pass_count = '0;
			upd.cnt_wdata.fail_count = fdt_pkg::COUNT_BITS'(fail_new);
			if (fail_new >= conf_lim) begin
				upd.cnt_wdata.status = fdt_pkg::STAT_DETECTED;
				upd.det_next         = 1'b1;
				if (cnt.status != fdt_pkg::STAT_DETECTED) begin
					upd.confirmed_now = 1'b1;
					upd.fired_actions = lim.actions;
				end
			end else begin
				upd.cnt_wdata.status = fdt_pkg::STAT_PENDING;
			end
			upd.fault_state = upd.cnt_wdata.status;
		end else if (item.diag_result == fdt_pkg::DIAG_PASS) begin
			upd.cnt_we               = 1'b1;
			upd.cnt_wdata.fail_count = '0;
			upd.cnt_wdata.pass_count = fdt_pkg::COUNT_BITS'(pass_new);
			upd.cnt_wdata.status     = (pass_new >= heal_lim) ? fdt_pkg::STAT_NONE
			                                                  : fdt_pkg::STAT_HEALING;
			upd.fault_state          = upd.cnt_wdata.status;
		end else begin
			// report with an undefined diagnostic code
			upd.error_flag = 1'b1;
		end
	end

endmodule

// ===== design/fault_debounce_table.sv =====
// the record read starts at the accepting edge, the update is evaluated in the EVAL
// state, and the response is registered when it fires, once the output register
// has room; a new request is taken only in IDLE, after the last one is written back,
// as the record memories are read at acceptance and updated and written back in EVAL
// reset: arst_n clears control, valid bits and the active bitmap and count;
// every fault reads as zeroed until written, so no clearing pass is needed
module fault_debounce_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fdt_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fdt_pkg::rsp_t rsp_data
);

	localparam int CNT_W = $bits(fdt_pkg::cnt_rec_t);
	localparam int LIM_W = $bits(fdt_pkg::lim_rec_t);

	fdt_pkg::ctl_state_t state_q, state_d;

	// request held while its records are read and evaluated
	fdt_pkg::req_t                  item_s1;
	logic                           cnt_vld_s1;
	logic                           lim_vld_s1;

	// per-entry written flags: counters drop on clear all, definitions only on reset
	logic [fdt_pkg::FAULT_COUNT-1:0] cnt_vld_q;
	logic [fdt_pkg::FAULT_COUNT-1:0] lim_vld_q;

	// detected flag per fault and the running total
	logic [fdt_pkg::FAULT_COUNT-1:0] det_q, det_d;
	logic [fdt_pkg::TOTAL_BITS-1:0]  total_q, total_d;
	logic [fdt_pkg::MASK_SPAN-1:0]   det_pad;

	logic                           rsp_valid_q;
	fdt_pkg::rsp_t                  rsp_q;

	logic                           accept;
	logic                           fire;
	logic                           rd_en;
	logic [fdt_pkg::ADDR_BITS-1:0]  rd_idx;
	logic [fdt_pkg::ADDR_BITS-1:0]  idx_s1;

	logic [CNT_W-1:0]               cnt_raw;
	logic [LIM_W-1:0]               lim_raw;
	fdt_pkg::cnt_rec_t              cnt_rd;
	fdt_pkg::lim_rec_t              lim_rd;
	fdt_pkg::upd_t                  upd;

	assign rd_idx = req_data.fault_id[fdt_pkg::ADDR_BITS-1:0];
	assign idx_s1 = item_s1.fault_id[fdt_pkg::ADDR_BITS-1:0];
	assign accept = req_valid && !req_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fdt_pkg::CTL_IDLE: begin
				if (req_valid) begin
					state_d = fdt_pkg::CTL_EVAL;
				end
			end
			fdt_pkg::CTL_EVAL: begin
				if (fire) begin
					state_d = fdt_pkg::CTL_IDLE;
				end
			end
			default: state_d = fdt_pkg::CTL_IDLE;
		endcase
	end

	// state outputs: evaluation waits only for room in the output register
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		fire      = 1'b0;
		unique case (state_q)
			fdt_pkg::CTL_IDLE: begin
				req_stall = 1'b0;
				rd_en     = req_valid;
			end
			fdt_pkg::CTL_EVAL: begin
				fire = !rsp_valid_q || !rsp_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdt_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the request and whether its entries were ever written
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= req_data;
			cnt_vld_s1 <= cnt_vld_q[rd_idx];
			lim_vld_s1 <= lim_vld_q[rd_idx];
		end
	end

	fdt_ram #(
		.WIDTH (CNT_W),
		.DEPTH (fdt_pkg::FAULT_COUNT)
	) u_cnt_ram (
		.clk   (clk),
		.we    (fire && upd.cnt_we),
		.waddr (idx_s1),
		.wdata (upd.cnt_wdata),
		.re    (rd_en),
		.raddr (rd_idx),
		.rdata (cnt_raw)
	);

	fdt_ram #(
		.WIDTH (LIM_W),
		.DEPTH (fdt_pkg::FAULT_COUNT)
	) u_lim_ram (
		.clk   (clk),
		.we    (fire && upd.lim_we),
		.waddr (idx_s1),
		.wdata (upd.lim_wdata),
		.re    (rd_en),
		.raddr (rd_idx),
		.rdata (lim_raw)
	);

	// an entry never written reads as all zero
	assign cnt_rd = cnt_vld_s1 ? fdt_pkg::cnt_rec_t'(cnt_raw) : '0;
	assign lim_rd = lim_vld_s1 ? fdt_pkg::lim_rec_t'(lim_raw) : '0;

	fdt_eval u_eval (
		.item (item_s1),
		.cnt  (cnt_rd),
		.lim  (lim_rd),
		.upd  (upd)
	);

	// detected bitmap and total after this request
	always_comb begin
		det_d   = det_q;
		total_d = total_q;
		if (upd.clear_all) begin
			det_d   = '0;
			total_d = '0;
		end else if (upd.cnt_we) begin
			det_d[idx_s1] = upd.det_next;
			if (upd.det_next && !det_q[idx_s1]) begin
				total_d = total_q + fdt_pkg::TOTAL_BITS'(1);
			end else if (!upd.det_next && det_q[idx_s1]) begin
				total_d = total_q - fdt_pkg::TOTAL_BITS'(1);
			end
		end
	end

	assign det_pad = fdt_pkg::MASK_SPAN'(det_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			lim_vld_q <= '0;
			det_q     <= '0;
			total_q   <= '0;
		end else if (fire) begin
			det_q   <= det_d;
			total_q <= total_d;
			if (upd.clear_all) begin
				cnt_vld_q <= '0;
			end else if (upd.cnt_we) begin
				cnt_vld_q[idx_s1] <= 1'b1;
			end
			if (upd.lim_we) begin
				lim_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// output register, refilled as soon as the previous response is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.error_flag    <= upd.error_flag;
			rsp_q.fault_state   <= upd.fault_state;
			rsp_q.confirmed_now <= upd.confirmed_now;
			rsp_q.fired_actions <= upd.fired_actions;
			rsp_q.active_mask   <= det_pad[fdt_pkg::MASK_BITS-1:0];
			// total saturates at 63 in the 6-bit count; the table holds 32 faults
			rsp_q.active_count  <= (total_d > fdt_pkg::TOTAL_CAP)
				? fdt_pkg::ACT_BITS'(fdt_pkg::TOTAL_CAP)
				: total_d[fdt_pkg::ACT_BITS-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
